@@ rtl/d2gd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// d2gd_pkg - shared definitions of the 2D gradient delta decoder
// Sample width, configuration port layout, register indexes and the
// default dimension limits used by the core.
// ----------------------------------------------------------------------------
package d2gd_pkg;

   // sample and residual width
   localparam int unsigned SAMPLE_W = 16;

   // configuration port layout
   localparam int unsigned CSR_IDX_W  = 4;
   localparam int unsigned CSR_DATA_W = 16;

   // raw register field widths
   localparam int unsigned GRID_WIDTH_W  = 13;
   localparam int unsigned GRID_HEIGHT_W = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = CSR_IDX_W'(1);

   // default dimension limits
   localparam int unsigned MAX_WIDTH_DEF  = 4096;
   localparam int unsigned MAX_HEIGHT_DEF = 65535;

endpackage : d2gd_pkg
`default_nettype wire

@@ rtl/delta2d_gradient_decoder_u16_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// delta2d_gradient_decoder_u16_core - 2D gradient delta decoder, 16 bits
// Rebuilds raster-ordered samples from residuals using a left/above/
// upper-left gradient prediction, with a one-row line buffer in block RAM.
// ----------------------------------------------------------------------------
// The decoder takes one request (residual plus end-of-data mark) per clock
// and returns one sample per request in the next cycle through an output
// register; with no back-pressure it sustains one request every cycle. That
// figure is set by the line buffer: a single-port-read RAM whose read for the
// next column is issued in the same cycle as the write of the current one,
// with a bypass when both hit the same entry (a one-column grid). The line
// buffer needs no clearing pass: after any restart only the top row is
// decoded, which never reads it. Writing either dimension register restarts
// decoding at the origin; write them only while the decoder is idle. A zero
// dimension counts as one and values above MAX_WIDTH / MAX_HEIGHT are clamped.
module delta2d_gradient_decoder_u16_core #(
   parameter int unsigned MAX_WIDTH  = d2gd_pkg::MAX_WIDTH_DEF,
   parameter int unsigned MAX_HEIGHT = d2gd_pkg::MAX_HEIGHT_DEF
) (
   input  wire                             clock,
   input  wire                             reset,
   // configuration
   input  wire                             csr_valid,
   output logic                            csr_ready,
   input  wire  [d2gd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire  [d2gd_pkg::CSR_DATA_W-1:0] csr_wdata,
   // request channel
   input  wire                             req_valid,
   output logic                            req_stall,
   input  wire  [d2gd_pkg::SAMPLE_W-1:0]   req_residual,
   input  wire                             req_end_of_data,
   // response channel
   output logic                            rsp_valid,
   input  wire                             rsp_stall,
   output logic [d2gd_pkg::SAMPLE_W-1:0]   rsp_sample,
   output logic                            rsp_frame_last,
   output logic                            rsp_length_error
);

   localparam int unsigned COL_W = $clog2(MAX_WIDTH);
   localparam int unsigned ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int unsigned SW    = d2gd_pkg::SAMPLE_W;
   localparam int unsigned GWW   = d2gd_pkg::GRID_WIDTH_W;
   localparam int unsigned GHW   = d2gd_pkg::GRID_HEIGHT_W;
   localparam logic [31:0] MaxW  = 32'(MAX_WIDTH);
   localparam logic [31:0] MaxH  = 32'(MAX_HEIGHT);

   // line buffer
   logic [SW-1:0]    row_mem [MAX_WIDTH];
   logic [SW-1:0]    above_ff;

   // position and neighbour registers
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [SW-1:0]    left_ff, left_in;
   logic [SW-1:0]    upleft_ff, upleft_in;
   logic [COL_W-1:0] last_col_ff, last_col_in;
   logic [ROW_W-1:0] last_row_ff, last_row_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]    rsp_sample_ff;
   logic             rsp_last_ff;
   logic             rsp_err_ff;

   logic             req_accept;
   logic             csr_write;
   logic [SW-1:0]    pred;
   logic [SW-1:0]    smp;
   logic             at_last_col;
   logic             frame_last;
   logic             len_err;
   logic             bypass;
   logic [GWW-1:0]   w_raw;
   logic [GHW-1:0]   h_raw;
   logic [31:0]      w_eff;
   logic [31:0]      h_eff;

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   // clamp the dimension being written and turn it into a last index
   always_comb begin
      w_raw = csr_wdata[GWW-1:0];
      h_raw = csr_wdata[GHW-1:0];
      if (w_raw == '0) begin
         w_eff = 32'd1;
      end else if (32'(w_raw) > MaxW) begin
         w_eff = MaxW;
      end else begin
         w_eff = 32'(w_raw);
      end
      if (h_raw == '0) begin
         h_eff = 32'd1;
      end else if (32'(h_raw) > MaxH) begin
         h_eff = MaxH;
      end else begin
         h_eff = 32'(h_raw);
      end
   end

   // predict, reconstruct and advance the raster position
   always_comb begin
      unique case ({row_ff == '0, col_ff == '0})
         2'b11:   pred = '0;
         2'b10:   pred = left_ff;
         2'b01:   pred = above_ff;
         default: pred = left_ff + above_ff - upleft_ff;
      endcase
      smp         = pred + req_residual;
      at_last_col = (col_ff == last_col_ff);
      frame_last  = at_last_col && (row_ff == last_row_ff);
      len_err     = req_end_of_data != frame_last;

      col_in      = col_ff;
      row_in      = row_ff;
      left_in     = left_ff;
      upleft_in   = upleft_ff;
      last_col_in = last_col_ff;
      last_row_in = last_row_ff;

      if (csr_write) begin
         unique case (csr_index)
            d2gd_pkg::CSR_GRID_WIDTH: begin
               last_col_in = COL_W'(w_eff - 32'd1);
               col_in      = '0;
               row_in      = '0;
               left_in     = '0;
               upleft_in   = '0;
            end
            d2gd_pkg::CSR_GRID_HEIGHT: begin
               last_row_in = ROW_W'(h_eff - 32'd1);
               col_in      = '0;
               row_in      = '0;
               left_in     = '0;
               upleft_in   = '0;
            end
            default: begin
            end
         endcase
      end else if (req_accept) begin
         if (frame_last || len_err) begin
            col_in    = '0;
            row_in    = '0;
            left_in   = '0;
            upleft_in = '0;
         end else if (at_last_col) begin
            col_in    = '0;
            row_in    = row_ff + ROW_W'(1);
            left_in   = '0;
            upleft_in = '0;
         end else begin
            col_in    = col_ff + COL_W'(1);
            left_in   = smp;
            upleft_in = above_ff;
         end
      end
   end

   // bypass the RAM when the next column is the one being written
   assign bypass = req_accept && (col_in == col_ff);

   // line buffer: write current column, prefetch next column
   always_ff @(posedge clock) begin
      if (req_accept) begin
         row_mem[col_ff] <= smp;
      end
      if (bypass) begin
         above_ff <= smp;
      end else begin
         above_ff <= row_mem[col_in];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         left_ff      <= '0;
         upleft_ff    <= '0;
         last_col_ff  <= '0;
         last_row_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         left_ff      <= left_in;
         upleft_ff    <= upleft_in;
         last_col_ff  <= last_col_in;
         last_row_ff  <= last_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the response until taken, load a new one on each request
   assign rsp_valid_in = req_accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_sample_ff <= smp;
         rsp_last_ff   <= frame_last;
         rsp_err_ff    <= len_err;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample       = rsp_sample_ff;
   assign rsp_frame_last   = rsp_last_ff;
   assign rsp_length_error = rsp_err_ff;

   // position never passes the configured grid
   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= last_col_ff)
      else $error("column position beyond grid width");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      row_ff <= last_row_ff)
      else $error("row position beyond grid height");

   // a frame end or length error restarts at the origin
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !csr_write && (frame_last || len_err))
      |=> (col_ff == '0 && row_ff == '0 && left_ff == '0 && upleft_ff == '0))
      else $error("decoder did not restart at the origin");

   // bypassed read returns the sample just written
   a_bypass: assert property (@(posedge clock) disable iff (reset)
      bypass |=> (above_ff == $past(smp)))
      else $error("line buffer bypass returned stale data");

   // every accepted request yields a pending response
   a_rsp_loaded: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted request produced no response");

endmodule : delta2d_gradient_decoder_u16_core
`default_nettype wire

@@ tb/sv/tb_delta2d_gradient_decoder_u16_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_delta2d_gradient_decoder_u16_core - testbench of the 2D gradient decoder
// Drives residual requests and grid dimension writes into the core, predicts
// every decoded sample with a behavioural line-buffer decoder of its own and
// compares each response, field by field, in arrival order. Covers the
// default grid, small grids, zero and oversized dimensions, a one-column
// grid, early and missing end marks, a long response hold-off and random
// frames under three idling profiles.
// ----------------------------------------------------------------------------
module tb_delta2d_gradient_decoder_u16_core;

   localparam int unsigned CYCLE_LIMIT  = 500000;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned DRAIN_SLACK  = 8;
   localparam int unsigned REPORT_LIMIT = 10;
   localparam int unsigned GRID_MAX_W   = d2gd_pkg::MAX_WIDTH_DEF;
   localparam int unsigned GRID_MAX_H   = d2gd_pkg::MAX_HEIGHT_DEF;
   localparam int unsigned COL_IDX_W    = $clog2(GRID_MAX_W);
   // index that maps to no register
   localparam logic [d2gd_pkg::CSR_IDX_W-1:0] CSR_SPARE_INDEX =
      d2gd_pkg::CSR_IDX_W'(15);

   typedef enum int {FRAME_CLEAN, FRAME_EARLY_END, FRAME_NO_END} frame_kind_type;

   typedef struct packed {
      logic [d2gd_pkg::SAMPLE_W-1:0] sample;
      logic                          frame_last;
      logic                          length_error;
   } decoded_type;

   // clock, reset and block ports
   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [d2gd_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [d2gd_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [d2gd_pkg::SAMPLE_W-1:0]   req_residual = '0;
   logic                            req_end_of_data = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [d2gd_pkg::SAMPLE_W-1:0]   rsp_sample;
   logic                            rsp_frame_last;
   logic                            rsp_length_error;

   // decoder prediction state
   logic [d2gd_pkg::SAMPLE_W-1:0] prev_row [0:GRID_MAX_W-1];
   logic [d2gd_pkg::SAMPLE_W-1:0] left_val = '0;
   logic [d2gd_pkg::SAMPLE_W-1:0] upper_left_val = '0;
   int unsigned                   pos_col = 0;
   int unsigned                   pos_row = 0;
   int unsigned                   eff_cols = 1;
   int unsigned                   eff_rows = 1;

   decoded_type expected_samples[$];
   int unsigned items_sent = 0;
   int unsigned failures = 0;
   int unsigned cycle_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   bit          hold_request = 1'b0;
   int unsigned hold_left = 0;

   delta2d_gradient_decoder_u16_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_residual     (req_residual),
      .req_end_of_data  (req_end_of_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample       (rsp_sample),
      .rsp_frame_last   (rsp_frame_last),
      .rsp_length_error (rsp_length_error)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("delta2d_gradient_decoder_u16_core verification failed");
         $finish;
      end
   end

   function automatic void note_failure(input string msg);
      failures++;
      if (failures <= REPORT_LIMIT)
         $display("%0t: %s", $realtime, msg);
   endfunction

   // return decoding to the grid origin
   function automatic void restart_decode();
      pos_col        = 0;
      pos_row        = 0;
      left_val       = '0;
      upper_left_val = '0;
   endfunction

   // mirror a register write into the prediction state
   function automatic void apply_csr(input logic [d2gd_pkg::CSR_IDX_W-1:0] idx,
                                     input logic [d2gd_pkg::CSR_DATA_W-1:0] data);
      logic [d2gd_pkg::GRID_WIDTH_W-1:0]  w_raw;
      logic [d2gd_pkg::GRID_HEIGHT_W-1:0] h_raw;
      w_raw = data[d2gd_pkg::GRID_WIDTH_W-1:0];
      h_raw = data[d2gd_pkg::GRID_HEIGHT_W-1:0];
      case (idx)
         d2gd_pkg::CSR_GRID_WIDTH: begin
            eff_cols = (w_raw == 0) ? 1 : ((w_raw > GRID_MAX_W) ? GRID_MAX_W : w_raw);
            restart_decode();
         end
         d2gd_pkg::CSR_GRID_HEIGHT: begin
            eff_rows = (h_raw == 0) ? 1 : ((h_raw > GRID_MAX_H) ? GRID_MAX_H : h_raw);
            restart_decode();
         end
         default: ;
      endcase
   endfunction

   // decode one residual and queue the sample it must produce
   function automatic void predict_sample(input logic [d2gd_pkg::SAMPLE_W-1:0] res,
                                          input logic eod);
      logic [COL_IDX_W-1:0]          col_idx;
      logic [d2gd_pkg::SAMPLE_W-1:0] above;
      logic [d2gd_pkg::SAMPLE_W-1:0] guess;
      logic [d2gd_pkg::SAMPLE_W-1:0] value;
      logic                          at_end;
      logic                          bad_len;
      decoded_type                   entry;
      col_idx = COL_IDX_W'(pos_col);
      above   = prev_row[col_idx];
      if (pos_row == 0 && pos_col == 0)
         guess = '0;
      else if (pos_row == 0)
         guess = left_val;
      else if (pos_col == 0)
         guess = above;
      else
         guess = left_val + above - upper_left_val;
      value = guess + res;
      prev_row[col_idx] = value;
      upper_left_val    = above;
      left_val          = value;
      at_end  = (pos_col + 1 == eff_cols) && (pos_row + 1 == eff_rows);
      bad_len = (eod != at_end);
      if (at_end || bad_len) begin
         restart_decode();
      end else if (pos_col + 1 >= eff_cols) begin
         pos_col        = 0;
         pos_row        = pos_row + 1;
         left_val       = '0;
         upper_left_val = '0;
      end else begin
         pos_col = pos_col + 1;
      end
      entry.sample       = value;
      entry.frame_last   = at_end;
      entry.length_error = bad_len;
      expected_samples.push_back(entry);
   endfunction

   function automatic logic [d2gd_pkg::SAMPLE_W-1:0] rand_residual();
      int unsigned pick;
      pick = $urandom_range(7);
      case (pick)
         0:       return '0;
         1:       return '1;
         2:       return d2gd_pkg::SAMPLE_W'($urandom_range(3));
         default: return d2gd_pkg::SAMPLE_W'($urandom);
      endcase
   endfunction

   // offer one request, with random gaps, and hold it until accepted
   task automatic send_residual(input logic [d2gd_pkg::SAMPLE_W-1:0] res,
                                input logic eod);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_residual    <= res;
      req_end_of_data <= eod;
      do @(posedge clock); while (!(req_valid && !req_stall));
      predict_sample(res, eod);
      items_sent++;
   endtask

   // drop the request line and wait until every sample is back
   task automatic drain_decoder();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_samples.size() != 0)
         @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   task automatic write_csr(input logic [d2gd_pkg::CSR_IDX_W-1:0] idx,
                            input logic [d2gd_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      apply_csr(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // finish the current frame from wherever decoding stands
   task automatic send_frame(input frame_kind_type kind);
      int unsigned remaining;
      int unsigned cut;
      int unsigned k;
      logic        end_here;
      remaining = (eff_rows - pos_row) * eff_cols - pos_col;
      if (kind == FRAME_EARLY_END && remaining > 1)
         cut = $urandom_range(remaining - 2, 0);
      else
         cut = remaining - 1;
      for (k = 0; k <= cut; k++) begin
         end_here = (kind == FRAME_NO_END) ? 1'b0 : (k == cut);
         send_residual(rand_residual(), end_here);
      end
   endtask

   // unstructured requests with stray end marks
   task automatic send_noise(input int unsigned count);
      repeat (count)
         send_residual(rand_residual(), ($urandom_range(5) == 0));
   endtask

   // response stall: long hold-off on request, random otherwise
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // compare every accepted sample with the oldest prediction
   always @(posedge clock) begin : check_samples
      decoded_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_samples.size() == 0) begin
            note_failure($sformatf("unexpected sample %h last %b err %b",
                                   rsp_sample, rsp_frame_last, rsp_length_error));
         end else begin
            want = expected_samples.pop_front();
            if (rsp_sample !== want.sample || rsp_frame_last !== want.frame_last ||
                rsp_length_error !== want.length_error)
               note_failure($sformatf(
                  "sample exp %h got %h, last exp %b got %b, err exp %b got %b",
                  want.sample, rsp_sample, want.frame_last, rsp_frame_last,
                  want.length_error, rsp_length_error));
         end
      end
   end

   // default 1x1 grid: clean end, missing end, minimum residual
   task automatic test_reset_defaults();
      send_residual(16'hFFFF, 1'b1);
      send_residual(16'h0001, 1'b0);
      send_residual(16'h0000, 1'b1);
   endtask

   // 3x2 grid: gradient wrap, early end mark, missing end mark
   task automatic test_small_grid();
      drain_decoder();
      write_csr(d2gd_pkg::CSR_GRID_WIDTH, 16'd3);
      write_csr(d2gd_pkg::CSR_GRID_HEIGHT, 16'd2);
      send_residual(16'hFFFF, 1'b0);
      send_residual(16'h0001, 1'b0);
      send_residual(16'h8000, 1'b0);
      send_residual(16'h0001, 1'b0);
      send_residual(16'hFFFF, 1'b0);
      send_residual(16'h0000, 1'b1);
      send_residual(16'h1234, 1'b0);
      send_residual(16'h4321, 1'b1);
      send_frame(FRAME_NO_END);
   endtask

   // zero dimensions, a spare index and a one-column grid
   task automatic test_dimension_edges();
      drain_decoder();
      write_csr(d2gd_pkg::CSR_GRID_WIDTH, 16'd0);
      write_csr(d2gd_pkg::CSR_GRID_HEIGHT, 16'd0);
      send_residual(16'h7FFF, 1'b1);
      drain_decoder();
      write_csr(d2gd_pkg::CSR_GRID_WIDTH, 16'd1);
      write_csr(d2gd_pkg::CSR_GRID_HEIGHT, 16'd3);
      write_csr(CSR_SPARE_INDEX, 16'hFFFF);
      send_residual(16'hAAAA, 1'b0);
      send_residual(16'h5555, 1'b0);
      send_residual(16'hFFFF, 1'b1);
   endtask

   // oversized width clamps to the buffer size; both grids end early
   task automatic test_extreme_dimensions();
      drain_decoder();
      write_csr(d2gd_pkg::CSR_GRID_WIDTH, 16'hFFFF);
      write_csr(d2gd_pkg::CSR_GRID_HEIGHT, 16'd0);
      repeat (20) send_residual(rand_residual(), 1'b0);
      send_residual(rand_residual(), 1'b1);
      drain_decoder();
      write_csr(d2gd_pkg::CSR_GRID_WIDTH, 16'd2);
      write_csr(d2gd_pkg::CSR_GRID_HEIGHT, 16'hFFFF);
      repeat (12) send_residual(rand_residual(), 1'b0);
      send_residual(rand_residual(), 1'b1);
   endtask

   // hold responses off while requests keep coming, so the core backs up
   task automatic test_back_pressure();
      drain_decoder();
      write_csr(d2gd_pkg::CSR_GRID_WIDTH, 16'd8);
      write_csr(d2gd_pkg::CSR_GRID_HEIGHT, 16'd8);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_request  = 1'b1;
      send_frame(FRAME_CLEAN);
      send_frame(FRAME_CLEAN);
   endtask

   // mostly well-formed random frames, some broken ones and some noise
   task automatic run_random_phase(input int unsigned send_pct,
                                   input int unsigned stall_pct,
                                   input int unsigned item_goal);
      int unsigned start_count;
      int unsigned pick;
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      start_count   = items_sent;
      while (items_sent - start_count < item_goal) begin
         if ($urandom_range(99) < 30) begin
            drain_decoder();
            pick = $urandom_range(2);
            if (pick != 1)
               write_csr(d2gd_pkg::CSR_GRID_WIDTH,
                         d2gd_pkg::CSR_DATA_W'($urandom_range(12)));
            if (pick != 0)
               write_csr(d2gd_pkg::CSR_GRID_HEIGHT,
                         d2gd_pkg::CSR_DATA_W'($urandom_range(6)));
         end
         pick = $urandom_range(99);
         if (pick < 70)
            send_frame(FRAME_CLEAN);
         else if (pick < 82)
            send_frame(FRAME_EARLY_END);
         else if (pick < 92)
            send_frame(FRAME_NO_END);
         else
            send_noise($urandom_range(6, 1));
      end
   endtask

   task automatic test_random_traffic();
      run_random_phase(36, 47, 410);
      run_random_phase(47, 36, 410);
      run_random_phase(0, 0, 400);
   endtask

   initial begin
      foreach (prev_row[i])
         prev_row[i] = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_small_grid();
      test_dimension_edges();
      test_extreme_dimensions();
      test_back_pressure();
      test_random_traffic();

      // let the last samples out, then count any still owed
      drain_decoder();
      if (expected_samples.size() != 0)
         note_failure($sformatf("%0d samples never arrived", expected_samples.size()));
      if (failures == 0) begin
         $display("delta2d_gradient_decoder_u16_core verification clean");
      end else begin
         $display("delta2d_gradient_decoder_u16_core verification failed");
      end
      $finish;
   end

endmodule
